@@ rtl/fsqrt_pkg.sv @@
// Shared types and constants of the binary32 Newton square-root core.
package fsqrt_pkg;

    localparam int WORD_W  = 32;
    localparam int ITER_W  = 3;
    localparam int EXP_W   = 11;  // signed working exponent
    localparam int MANT_W  = 27;  // hidden bit, 23 fraction bits, guard, round, sticky
    localparam int DIV_STEPS = 27;
    localparam int STEP_W  = 5;

    localparam logic [ITER_W-1:0] ITER_RESET  = 3'd3;
    localparam logic [WORD_W-1:0] SMALL_LIMIT = 32'h0080_0000;
    localparam logic [WORD_W-1:0] GUESS_BIAS  = 32'h2000_0000 - 32'h0040_0000 - 32'd307410;
    localparam logic [WORD_W-1:0] CANON_NAN   = 32'h7fc0_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UNPACK,
        OP_NORM,
        OP_PACK,
        OP_GUESS,
        OP_DIV_SETUP,
        OP_NORM_AB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_ADD_SETUP,
        OP_ADD_EXEC,
        OP_OUT
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Q,
        SEL_R
    } reg_sel_t;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_UP32,
        ADJ_HALF,
        ADJ_DOWN16
    } adj_sel_t;

    typedef struct packed {
        dp_op_t   op;
        reg_sel_t sel;
        adj_sel_t adj;
    } dp_cmd_t;

    typedef struct packed {
        logic a_done;
        logic b_done;
        logic spec;
        logic scaled;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE,
        ST_GUESS,
        ST_LOOP,
        ST_U_NORM,
        ST_U_PACK,
        ST_DIV_NORM,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_DIV_PACK,
        ST_ADD_SETUP,
        ST_ADD_EXEC,
        ST_ADD_NORM,
        ST_ADD_PACK,
        ST_HALF,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_HALF,
        PH_FINAL
    } phase_t;

endpackage

@@ rtl/fsqrt_ctrl.sv @@
// Sequencer of the square-root core: steps the datapath through scaling, guess and Newton steps.
module fsqrt_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      cfg_wr_en,
    input  logic [fsqrt_pkg::ITER_W-1:0] cfg_wr_data,
    input  fsqrt_pkg::dp_stat_t       stat,
    output fsqrt_pkg::dp_cmd_t        cmd
);
    import fsqrt_pkg::*;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [ITER_W-1:0]   iter_cfg_reg;
    logic [ITER_W-1:0]   cnt_reg, cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_PRE;
            iter_cfg_reg <= ITER_RESET;
            cnt_reg      <= '0;
            step_reg     <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            if (cfg_wr_en) begin
                iter_cfg_reg <= cfg_wr_data;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_PRE;
            ST_PRE:       state_next = stat.scaled ? ST_U_NORM : ST_GUESS;
            ST_GUESS:     state_next = ST_LOOP;
            ST_LOOP: begin
                if (cnt_reg != '0) begin
                    state_next = ST_DIV_NORM;
                end else begin
                    state_next = stat.scaled ? ST_U_NORM : ST_OUT;
                end
            end
            ST_U_NORM:    if (stat.a_done) state_next = ST_U_PACK;
            ST_U_PACK: begin
                unique case (phase_reg)
                    PH_PRE:   state_next = ST_GUESS;
                    PH_HALF:  state_next = ST_LOOP;
                    PH_FINAL: state_next = ST_OUT;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_DIV_NORM: begin
                if (stat.spec) begin
                    state_next = ST_DIV_PACK;
                end else if (stat.a_done && stat.b_done) begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:  state_next = ST_DIV_STEP;
            ST_DIV_STEP:  if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = ST_DIV_END;
            ST_DIV_END:   state_next = ST_DIV_PACK;
            ST_DIV_PACK:  state_next = ST_ADD_SETUP;
            ST_ADD_SETUP: state_next = ST_ADD_EXEC;
            ST_ADD_EXEC:  state_next = ST_ADD_NORM;
            ST_ADD_NORM:  if (stat.a_done) state_next = ST_ADD_PACK;
            ST_ADD_PACK:  state_next = ST_HALF;
            ST_HALF:      state_next = ST_U_NORM;
            ST_OUT:       if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        cmd        = '{op: OP_NONE, sel: SEL_X, adj: ADJ_NONE};
        s_tready   = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_PRE: begin
                if (stat.scaled) begin
                    cmd.op     = OP_UNPACK;
                    cmd.sel    = SEL_X;
                    phase_next = PH_PRE;
                end
            end
            ST_GUESS: begin
                cmd.op   = OP_GUESS;
                cnt_next = iter_cfg_reg;
            end
            ST_LOOP: begin
                if (cnt_reg != '0) begin
                    cmd.op = OP_DIV_SETUP;
                end else if (stat.scaled) begin
                    cmd.op     = OP_UNPACK;
                    cmd.sel    = SEL_R;
                    phase_next = PH_FINAL;
                end
            end
            ST_U_NORM:   cmd.op = OP_NORM;
            ST_U_PACK: begin
                cmd.op = OP_PACK;
                unique case (phase_reg)
                    PH_PRE: begin
                        cmd.sel = SEL_X;
                        cmd.adj = ADJ_UP32;
                    end
                    PH_HALF: begin
                        cmd.sel  = SEL_R;
                        cmd.adj  = ADJ_HALF;
                        cnt_next = cnt_reg - ITER_W'(1);
                    end
                    PH_FINAL: begin
                        cmd.sel = SEL_R;
                        cmd.adj = ADJ_DOWN16;
                    end
                    default: begin
                        cmd.sel = SEL_R;
                        cmd.adj = ADJ_DOWN16;
                    end
                endcase
            end
            ST_DIV_NORM: if (!stat.spec) cmd.op = OP_NORM_AB;
            ST_DIV_INIT: begin
                cmd.op    = OP_DIV_INIT;
                step_next = '0;
            end
            ST_DIV_STEP: begin
                cmd.op    = OP_DIV_STEP;
                step_next = step_reg + STEP_W'(1);
            end
            ST_DIV_END:  cmd.op = OP_DIV_END;
            ST_DIV_PACK: begin
                cmd.op  = OP_PACK;
                cmd.sel = SEL_Q;
            end
            ST_ADD_SETUP: cmd.op = OP_ADD_SETUP;
            ST_ADD_EXEC:  if (!stat.spec) cmd.op = OP_ADD_EXEC;
            ST_ADD_NORM:  cmd.op = OP_NORM;
            ST_ADD_PACK: begin
                cmd.op  = OP_PACK;
                cmd.sel = SEL_Q;
            end
            ST_HALF: begin
                cmd.op     = OP_UNPACK;
                cmd.sel    = SEL_Q;
                phase_next = PH_HALF;
            end
            ST_OUT:      if (stat.out_free) cmd.op = OP_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/fsqrt_dp.sv @@
// Datapath of the square-root core: operand registers, bit-serial divider, adder, rounder.
module fsqrt_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [fsqrt_pkg::WORD_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fsqrt_pkg::WORD_W-1:0] m_tdata,
    input  fsqrt_pkg::dp_cmd_t         cmd,
    output fsqrt_pkg::dp_stat_t        stat
);
    import fsqrt_pkg::*;

    logic [WORD_W-1:0]        x_reg, x_next;
    logic [WORD_W-1:0]        q_reg, q_next;
    logic [WORD_W-1:0]        r_reg, r_next;
    logic                     scaled_reg, scaled_next;
    logic                     sa_reg, sa_next;
    logic signed [EXP_W-1:0]  ea_reg, ea_next;
    logic [MANT_W-1:0]        ma_reg, ma_next;
    logic                     sb_reg, sb_next;
    logic signed [EXP_W-1:0]  eb_reg, eb_next;
    logic [MANT_W-1:0]        mb_reg, mb_next;
    logic [MANT_W:0]          rem_reg, rem_next;
    logic [MANT_W-1:0]        quo_reg, quo_next;
    logic                     spec_reg, spec_next;
    logic [WORD_W-1:0]        spec_val_reg, spec_val_next;
    logic [WORD_W-1:0]        out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]        src_word;
    logic signed [EXP_W-1:0]  adj_off;
    logic [WORD_W-1:0]        packed_word;
    logic signed [EXP_W-1:0]  exp_gap;
    logic [MANT_W-1:0]        mb_align;
    logic [MANT_W-1:0]        mb_shift;
    logic [MANT_W-1:0]        al_mask;
    logic                     al_lost;
    logic [MANT_W:0]          add_sum;
    logic [MANT_W-1:0]        sub_dif;
    logic                     div_ge;
    logic [MANT_W:0]          div_rem;
    logic                     div_sticky;
    logic                     sx;
    logic [WORD_W-1:0]        big_word, lit_word;

    function automatic logic is_nan(input logic [WORD_W-1:0] w);
        return (w[30:23] == 8'hff) && (w[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [WORD_W-1:0] w);
        return (w[30:23] == 8'hff) && (w[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [WORD_W-1:0] w);
        return w[30:0] == 31'd0;
    endfunction

    function automatic logic signed [EXP_W-1:0] unpack_e(input logic [WORD_W-1:0] w);
        return (w[30:23] == 8'h00) ? EXP_W'(1) : EXP_W'({3'b000, w[30:23]});
    endfunction

    function automatic logic [MANT_W-1:0] unpack_m(input logic [WORD_W-1:0] w);
        return {(w[30:23] != 8'h00), w[22:0], 3'b000};
    endfunction

    // round to nearest even; m holds the hidden bit at the top when e >= 1
    function automatic logic [WORD_W-1:0] pack_f(input logic s,
                                                 input logic signed [EXP_W-1:0] e,
                                                 input logic [MANT_W-1:0] m);
        logic signed [EXP_W-1:0] sh_full;
        logic [4:0]              sh;
        logic [MANT_W-1:0]       mm;
        logic [MANT_W-1:0]       mask;
        logic                    lost;
        logic [30:0]             mag;
        logic                    inc;
        sh_full = EXP_W'(1) - e;
        sh      = '0;
        mask    = '0;
        if (e >= EXP_W'(255)) begin
            return {s, 8'hff, 23'd0};
        end
        if (e >= EXP_W'(1)) begin
            mm   = m;
            lost = 1'b0;
            mag  = {e[7:0], m[25:3]};
        end else begin
            if (sh_full >= EXP_W'(MANT_W)) begin
                mm   = '0;
                lost = |m;
            end else begin
                sh   = sh_full[4:0];
                mask = (MANT_W'(1) << sh) - MANT_W'(1);
                lost = |(m & mask);
                mm   = m >> sh;
            end
            mag = {8'h00, mm[25:3]};
        end
        inc = mm[2] & (mm[1] | mm[0] | lost | mm[3]);
        return {s, mag + {30'd0, inc}};
    endfunction

    always_comb begin
        unique case (cmd.sel)
            SEL_X:   src_word = x_reg;
            SEL_Q:   src_word = q_reg;
            SEL_R:   src_word = r_reg;
            default: src_word = r_reg;
        endcase
        unique case (cmd.adj)
            ADJ_NONE:   adj_off = EXP_W'(0);
            ADJ_UP32:   adj_off = EXP_W'(32);
            ADJ_HALF:   adj_off = -EXP_W'(1);
            ADJ_DOWN16: adj_off = -EXP_W'(16);
            default:    adj_off = EXP_W'(0);
        endcase
        packed_word = spec_reg ? spec_val_reg : pack_f(sa_reg, ea_reg + adj_off, ma_reg);

        // alignment for the adder
        exp_gap  = ea_reg - eb_reg;
        mb_shift = '0;
        al_mask  = '0;
        if (exp_gap >= EXP_W'(MANT_W)) begin
            al_lost = |mb_reg;
        end else begin
            al_mask  = (MANT_W'(1) << exp_gap[4:0]) - MANT_W'(1);
            al_lost  = |(mb_reg & al_mask);
            mb_shift = mb_reg >> exp_gap[4:0];
        end
        mb_align = mb_shift | {{(MANT_W-1){1'b0}}, al_lost};
        add_sum  = {1'b0, ma_reg} + {1'b0, mb_align};
        sub_dif  = ma_reg - mb_align;

        div_ge     = rem_reg >= {1'b0, mb_reg};
        div_rem    = div_ge ? rem_reg - {1'b0, mb_reg} : rem_reg;
        div_sticky = rem_reg != '0;

        big_word = (r_reg[30:0] >= q_reg[30:0]) ? r_reg : q_reg;
        lit_word = (r_reg[30:0] >= q_reg[30:0]) ? q_reg : r_reg;
        sx       = x_reg[31] ^ r_reg[31];
    end

    always_comb begin
        x_next         = x_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        scaled_next    = scaled_reg;
        sa_next        = sa_reg;
        ea_next        = ea_reg;
        ma_next        = ma_reg;
        sb_next        = sb_reg;
        eb_next        = eb_reg;
        mb_next        = mb_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        spec_next      = spec_reg;
        spec_val_next  = spec_val_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                x_next      = s_tdata;
                scaled_next = s_tdata < SMALL_LIMIT;
            end
            OP_UNPACK: begin
                sa_next       = src_word[31];
                ea_next       = unpack_e(src_word);
                spec_val_next = src_word;
                spec_next     = (src_word[30:23] == 8'hff) || is_zero(src_word);
                ma_next       = spec_next ? '0 : unpack_m(src_word);
            end
            OP_NORM: begin
                if (!ma_reg[MANT_W-1] && ma_reg != '0) begin
                    ma_next = {ma_reg[MANT_W-2:0], 1'b0};
                    ea_next = ea_reg - EXP_W'(1);
                end
            end
            OP_NORM_AB: begin
                if (!ma_reg[MANT_W-1]) begin
                    ma_next = {ma_reg[MANT_W-2:0], 1'b0};
                    ea_next = ea_reg - EXP_W'(1);
                end
                if (!mb_reg[MANT_W-1]) begin
                    mb_next = {mb_reg[MANT_W-2:0], 1'b0};
                    eb_next = eb_reg - EXP_W'(1);
                end
            end
            OP_PACK: begin
                unique case (cmd.sel)
                    SEL_X:   x_next = packed_word;
                    SEL_Q:   q_next = packed_word;
                    SEL_R:   r_next = packed_word;
                    default: r_next = packed_word;
                endcase
            end
            OP_GUESS: begin
                r_next = GUESS_BIAS + {1'b0, x_reg[WORD_W-1:1]};
            end
            OP_DIV_SETUP: begin
                // x / r
                sa_next   = x_reg[31];
                ea_next   = unpack_e(x_reg);
                ma_next   = unpack_m(x_reg);
                sb_next   = r_reg[31];
                eb_next   = unpack_e(r_reg);
                mb_next   = unpack_m(r_reg);
                spec_next = 1'b1;
                priority if (is_nan(x_reg) || is_nan(r_reg)) begin
                    spec_val_next = CANON_NAN;
                end else if (is_zero(r_reg)) begin
                    spec_val_next = is_zero(x_reg) ? CANON_NAN : {sx, 8'hff, 23'd0};
                end else if (is_inf(x_reg)) begin
                    spec_val_next = is_inf(r_reg) ? CANON_NAN : {sx, 8'hff, 23'd0};
                end else if (is_inf(r_reg) || is_zero(x_reg)) begin
                    spec_val_next = {sx, 31'd0};
                end else begin
                    spec_next = 1'b0;
                end
            end
            OP_DIV_INIT: begin
                rem_next = {1'b0, ma_reg};
                quo_next = '0;
                ea_next  = ea_reg - eb_reg + EXP_W'(127);
                sa_next  = sa_reg ^ sb_reg;
            end
            OP_DIV_STEP: begin
                quo_next = {quo_reg[MANT_W-2:0], div_ge};
                rem_next = {div_rem[MANT_W-1:0], 1'b0};
            end
            OP_DIV_END: begin
                if (quo_reg[MANT_W-1]) begin
                    ma_next = {quo_reg[MANT_W-1:1], quo_reg[0] | div_sticky};
                end else begin
                    ma_next = {quo_reg[MANT_W-2:0], div_sticky};
                    ea_next = ea_reg - EXP_W'(1);
                end
            end
            OP_ADD_SETUP: begin
                // r + q, larger magnitude in A
                sa_next   = big_word[31];
                ea_next   = unpack_e(big_word);
                ma_next   = unpack_m(big_word);
                sb_next   = lit_word[31];
                eb_next   = unpack_e(lit_word);
                mb_next   = unpack_m(lit_word);
                spec_next = 1'b1;
                priority if (is_nan(r_reg) || is_nan(q_reg)) begin
                    spec_val_next = CANON_NAN;
                end else if (is_inf(r_reg) && is_inf(q_reg) && (r_reg[31] != q_reg[31])) begin
                    spec_val_next = CANON_NAN;
                end else if (is_inf(r_reg) || is_zero(q_reg)) begin
                    spec_val_next = is_zero(r_reg) ? {r_reg[31] & q_reg[31], 31'd0} : r_reg;
                end else if (is_inf(q_reg) || is_zero(r_reg)) begin
                    spec_val_next = q_reg;
                end else begin
                    spec_next = 1'b0;
                end
                if (spec_next) ma_next = '0;
            end
            OP_ADD_EXEC: begin
                if (sa_reg == sb_reg) begin
                    if (add_sum[MANT_W]) begin
                        ma_next = {add_sum[MANT_W:2], add_sum[1] | add_sum[0]};
                        ea_next = ea_reg + EXP_W'(1);
                    end else begin
                        ma_next = add_sum[MANT_W-1:0];
                    end
                end else if (sub_dif == '0) begin
                    // exact cancellation gives +0
                    ma_next       = '0;
                    spec_next     = 1'b1;
                    spec_val_next = '0;
                end else begin
                    ma_next = sub_dif;
                end
            end
            OP_OUT: begin
                out_next       = is_nan(r_reg) ? CANON_NAN : r_reg;
                out_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        scaled_reg   <= scaled_next;
        sa_reg       <= sa_next;
        ea_reg       <= ea_next;
        ma_reg       <= ma_next;
        sb_reg       <= sb_next;
        eb_reg       <= eb_next;
        mb_reg       <= mb_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        spec_reg     <= spec_next;
        spec_val_reg <= spec_val_next;
        out_reg      <= out_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_reg;
    assign stat.a_done   = ma_reg[MANT_W-1] || (ma_reg == '0);
    assign stat.b_done   = mb_reg[MANT_W-1];
    assign stat.spec     = spec_reg;
    assign stat.scaled   = scaled_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

endmodule

@@ rtl/float32_sqrt_newton_core.sv @@
// Top level of the binary32 Newton square-root core.
//
//  channel  | signals                       | contents
//  ---------+-------------------------------+-------------------------------
//  s_       | s_tvalid s_tready s_tdata     | value_bits [31:0]
//  m_       | m_tvalid m_tready m_tdata     | root_bits [31:0]
//  cfg_     | cfg_wr_en cfg_wr_data         | iteration_count [2:0]
//
// One item at a time. Each Newton step is dominated by the bit-serial mantissa divider,
// which a special-case quotient skips. Positive subnormal operands and +0 add a prescale
// and a final rescale pass, and normalization shifts one bit at a time. Reset sets
// iteration_count to 3. A finished result waits in the output register; the next
// transfer in is taken meanwhile.
module float32_sqrt_newton_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fsqrt_pkg::WORD_W-1:0] s_tdata,   // [31:0] value_bits
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fsqrt_pkg::WORD_W-1:0] m_tdata,   // [31:0] root_bits
    input  logic                       cfg_wr_en,
    input  logic [fsqrt_pkg::ITER_W-1:0] cfg_wr_data
);
    import fsqrt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fsqrt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .cmd         (cmd)
    );

    fsqrt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
